>>> src/gowe_pkg.sv
package gowe_pkg;

   localparam int unsigned DataWidth       = 32;
   localparam int unsigned PinCountDefault = 32;

   typedef enum logic [1:0] {
      CMD_DATA_WRITE = 2'd0,
      CMD_TOGGLE_DIR = 2'd1,
      CMD_LOAD_DIR   = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      SEM_REPLACE  = 3'd0,
      SEM_OR       = 3'd1,
      SEM_AND      = 3'd2,
      SEM_XOR      = 3'd3,
      SEM_RESERVED = 3'd4,
      SEM_SAT_ADD  = 3'd5,
      SEM_SAT_SUB  = 3'd6,
      SEM_RECONFIG = 3'd7
   } sem_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_RESERVED = 2'd1,
      STATUS_RECONFIG = 2'd2
   } status_type;

   typedef logic [DataWidth-1:0] word_type;

   // Merge payload into current levels; unhandled codes keep current.
   function automatic word_type combine(input word_type cur, input word_type req,
                                        input sem_type op);
      logic [DataWidth:0] sum;
      word_type           res;
      sum = {1'b0, cur} + {1'b0, req};
      unique case (op)
         SEM_REPLACE: res = req;
         SEM_OR:      res = cur | req;
         SEM_AND:     res = cur & req;
         SEM_XOR:     res = cur ^ req;
         SEM_SAT_ADD: res = sum[DataWidth] ? '1 : sum[DataWidth-1:0];
         SEM_SAT_SUB: res = (cur > req) ? '0 : (req - cur);
         default:     res = cur;
      endcase
      return res;
   endfunction

endpackage

>>> src/gpio_output_write_engine.sv
// GPIO output write engine.
// Request channel (req_): one item per command. tdata carries the 32-bit
// value (write payload, toggle mask or direction mask); tuser carries the
// command and the write semantics. Every item yields exactly one response
// item on the rsp_ channel with the pin levels, the direction mask and a
// status code as they stand after that item.
// Each accepted request passes the request register, then the state update
// and the response register, which share one stage.
// Throughput: one item per cycle while the receiver takes responses; the
// state update is a single 32-bit bitwise merge or saturating add/subtract,
// so item N+1 sees the state left by item N with no bubble.
// Reset clears the pin levels and makes every pin an input.
// When the receiver stalls, the response register holds and the request
// register fills; ready then drops until the response is taken.
// Pins at or above PIN_COUNT are always inputs and read back as zero.
module gpio_output_write_engine
   import gowe_pkg::*;
#(
   parameter int unsigned PIN_COUNT = PinCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [4:0]  req_tuser,   // [1:0] cmd, [4:2] semantics
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] pin_levels, [63:32] direction_mask
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic                 req_valid_ff, req_valid_in;
   cmd_type              req_cmd_ff;
   sem_type              req_sem_ff;
   word_type             req_value_ff;

   logic [PIN_COUNT-1:0] levels_ff, levels_in;
   logic [PIN_COUNT-1:0] dir_ff, dir_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             rsp_levels_ff;
   word_type             rsp_dir_ff;
   status_type           rsp_status_ff, status_in;

   logic                 advance;
   word_type             cur_levels;
   word_type             merged;
   word_type             levels_ext, dir_ext;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cur_levels                = '0;
      cur_levels[PIN_COUNT-1:0] = levels_ff;
      merged    = combine(cur_levels, req_value_ff, req_sem_ff);
      levels_in = levels_ff;
      dir_in    = dir_ff;
      status_in = STATUS_OK;
      unique case (req_cmd_ff)
         CMD_DATA_WRITE: begin
            priority if (req_sem_ff == SEM_RESERVED) begin
               status_in = STATUS_RESERVED;
            end else if (req_sem_ff == SEM_RECONFIG) begin
               status_in = STATUS_RECONFIG;
            end else begin
               // only output pins take the merged value
               levels_in = (merged[PIN_COUNT-1:0] & dir_ff) | (levels_ff & ~dir_ff);
            end
         end
         CMD_TOGGLE_DIR: dir_in = dir_ff ^ req_value_ff[PIN_COUNT-1:0];
         CMD_LOAD_DIR:   dir_in = req_value_ff[PIN_COUNT-1:0];
         CMD_READ:       ;
         default:        ;
      endcase
      levels_ext                = '0;
      levels_ext[PIN_COUNT-1:0] = levels_in;
      dir_ext                   = '0;
      dir_ext[PIN_COUNT-1:0]    = dir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         levels_ff    <= '0;
         dir_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            levels_ff <= levels_in;
            dir_ff    <= dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_value_ff <= req_tdata;
         req_cmd_ff   <= cmd_type'(req_tuser[1:0]);
         req_sem_ff   <= sem_type'(req_tuser[4:2]);
      end
      if (advance) begin
         rsp_levels_ff <= levels_ext;
         rsp_dir_ff    <= dir_ext;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dir_ff, rsp_levels_ff};
   assign rsp_tuser  = rsp_status_ff;

   // a held request must not move while it waits for the response slot
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_value_ff)
         && $stable(req_cmd_ff) && $stable(req_sem_ff))
      else $error("request register changed while stalled");

   // state moves only when an item is retired
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(levels_ff) && $stable(dir_ff))
      else $error("pin state changed without an item");

   // input pins never change level
   a_input_pins: assert property (@(posedge clock) disable iff (reset)
      advance |-> ((levels_in ^ levels_ff) & ~dir_ff) == '0)
      else $error("input pin level changed");

   a_flag_only_on_write: assert property (@(posedge clock) disable iff (reset)
      advance && status_in != STATUS_OK |-> req_cmd_ff == CMD_DATA_WRITE
         && levels_in == levels_ff)
      else $error("flagged item changed levels or was not a write");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff != 2'd3)
      else $error("undefined status code");

endmodule
